### sv/resync_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// Resync frame deframer assertion macros
// Shared assertion forms; every use samples on clk and is off while in reset.
// ----------------------------------------------------------------------------
`ifndef RESYNC_FRAME_DEFRAMER_DEFINES_SVH
`define RESYNC_FRAME_DEFRAMER_DEFINES_SVH

// Condition must hold on every clock outside reset.
`define RFD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RFD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/rfd_pkg.sv
// ----------------------------------------------------------------------------
// Resync frame deframer package
// Sizes, register codes, result and configuration types, pointer wrap helper.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int WIN_DEPTH   = 64;
  localparam int HDR_BYTES   = 4;
  localparam int PTR_W       = $clog2(WIN_DEPTH);
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int BODY_LEN_W  = 6;
  localparam int LEN_W       = 16;
  localparam int KIND_MASK_W = 64;
  localparam int KIND_IDX_W  = $clog2(KIND_MASK_W);

  // Byte queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 1'd1;

  localparam logic [KIND_MASK_W-1:0] KIND_MASK_RST = 64'h0000_0000_0000_3FFF;
  localparam logic [LEN_W-1:0]       MAX_LEN_RST   = 16'd60;

  typedef struct packed {
    logic [KIND_MASK_W-1:0] kind_mask;
    logic [LEN_W-1:0]       max_len;
  } rfd_cfg_t;

  typedef struct packed {
    logic                  is_header;
    logic [BYTE_W-1:0]     frame_kind;
    logic [BYTE_W-1:0]     frame_tag;
    logic [BODY_LEN_W-1:0] body_length;
    logic [BYTE_W-1:0]     body_byte;
    logic                  last_of_frame;
    logic                  last_of_run;
  } rfd_res_t;

  // Wrap a window position; the sum is always below twice the depth.
  function automatic logic [PTR_W-1:0] ptr_wrap(input logic [FILL_W:0] sum);
    logic [FILL_W:0] d;
    if (sum >= (FILL_W+1)'(WIN_DEPTH)) begin
      d = sum - (FILL_W+1)'(WIN_DEPTH);
    end else begin
      d = sum;
    end
    return d[PTR_W-1:0];
  endfunction

endpackage

### sv/rfd_byte_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one link byte per beat.
// ----------------------------------------------------------------------------
interface rfd_byte_if import rfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/rfd_result_if.sv
// ----------------------------------------------------------------------------
// Deframed result channel
// Valid/ready channel carrying one header or body byte result per beat.
// ----------------------------------------------------------------------------
interface rfd_result_if import rfd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  is_header;
  logic [BYTE_W-1:0]     frame_kind;
  logic [BYTE_W-1:0]     frame_tag;
  logic [BODY_LEN_W-1:0] body_length;
  logic [BYTE_W-1:0]     body_byte;
  logic                  last_of_frame;
  logic                  last_of_run;

  modport source (output valid, output is_header, output frame_kind, output frame_tag,
                  output body_length, output body_byte, output last_of_frame,
                  output last_of_run, input ready);
  modport sink   (input valid, input is_header, input frame_kind, input frame_tag,
                  input body_length, input body_byte, input last_of_frame,
                  input last_of_run, output ready);
endinterface

### sv/rfd_byte_queue.sv
// ----------------------------------------------------------------------------
// Deframer front queue
// Accepts received bytes and buffers them until the scanner takes them.
// ----------------------------------------------------------------------------
module rfd_byte_queue import rfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rfd_byte_if.sink     in_ch,
  rfd_byte_if.source   q_ch
);

  logic [BYTE_W-1:0] q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_ch.ready  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_ch.valid   = (cnt_r != '0);
  assign q_ch.rx_byte = q_mem[rd_ptr_r];

  assign push = in_ch.valid & in_ch.ready;
  assign pop  = q_ch.valid & q_ch.ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### sv/rfd_scanner.sv
// ----------------------------------------------------------------------------
// Deframer back end scanner
// Appends queued bytes to a circular window memory, scans for headers,
// drops bytes on false sync and emits header and body results.
// ----------------------------------------------------------------------------
`include "resync_frame_deframer_defines.svh"

module rfd_scanner import rfd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  rfd_cfg_t      cfg,
  rfd_byte_if.sink      q_ch,
  rfd_result_if.source  out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_KIND = 3'd2;
  localparam logic [2:0] S_TAG  = 3'd3;
  localparam logic [2:0] S_LHI  = 3'd4;
  localparam logic [2:0] S_LLO  = 3'd5;
  localparam logic [2:0] S_BODY = 3'd6;
  localparam logic [2:0] S_END  = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [BYTE_W-1:0] kind_r, kind_nxt;
  logic [BYTE_W-1:0] tag_r, tag_nxt;
  logic [BYTE_W-1:0] hi_r, hi_nxt;
  logic [LEN_W-1:0]  blen_r, blen_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;

  logic [BYTE_W-1:0] win_mem [WIN_DEPTH];
  logic [BYTE_W-1:0] rdata_r;
  logic              rd_en, wr_en;
  logic [FILL_W-1:0] rd_off;
  logic [PTR_W-1:0]  rd_addr, wr_addr;

  rfd_res_t          held_r, held_nxt, out_r, out_nxt, emit_item;
  logic              held_v_r, held_v_nxt, out_v_r, out_v_nxt;
  logic              out_take, can_emit, emit, flush;

  logic [LEN_W-1:0]  blen_w;
  logic [FILL_W-1:0] tot_w;
  logic              kind_ok;
  logic              body_last;

  assign q_ch.ready = (state_r == S_IDLE);

  assign out_take = out_v_r & out_ch.ready;
  assign can_emit = !held_v_r || !out_v_r || out_take;

  assign blen_w    = {hi_r, rdata_r};
  assign tot_w     = FILL_W'(blen_r) + FILL_W'(HDR_BYTES);
  assign kind_ok   = (rdata_r < BYTE_W'(KIND_MASK_W)) &&
                     cfg.kind_mask[rdata_r[KIND_IDX_W-1:0]];
  assign body_last = (LEN_W'(cnt_r) + LEN_W'(1)) == blen_r;
  assign rd_addr   = ptr_wrap((FILL_W+1)'(head_r) + (FILL_W+1)'(rd_off));

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    kind_nxt  = kind_r;
    tag_nxt   = tag_r;
    hi_nxt    = hi_r;
    blen_nxt  = blen_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    rd_off    = '0;
    wr_en     = 1'b0;
    wr_addr   = ptr_wrap((FILL_W+1)'(head_r) + (FILL_W+1)'(fill_r));
    emit      = 1'b0;
    emit_item = '0;
    flush     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_ch.valid) begin
          wr_en = 1'b1;
          // Full window: the new byte overwrites the oldest slot.
          if (fill_r == FILL_W'(WIN_DEPTH)) begin
            head_nxt = ptr_wrap((FILL_W+1)'(head_r) + (FILL_W+1)'(1));
          end else begin
            fill_nxt = fill_r + FILL_W'(1);
          end
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (fill_r < FILL_W'(HDR_BYTES)) begin
          state_nxt = S_END;
        end else begin
          rd_en     = 1'b1;
          rd_off    = FILL_W'(0);
          state_nxt = S_KIND;
        end
      end
      S_KIND: begin
        if (!kind_ok) begin
          head_nxt  = ptr_wrap((FILL_W+1)'(head_r) + (FILL_W+1)'(1));
          fill_nxt  = fill_r - FILL_W'(1);
          state_nxt = S_CHK;
        end else begin
          kind_nxt  = rdata_r;
          rd_en     = 1'b1;
          rd_off    = FILL_W'(1);
          state_nxt = S_TAG;
        end
      end
      S_TAG: begin
        tag_nxt   = rdata_r;
        rd_en     = 1'b1;
        rd_off    = FILL_W'(2);
        state_nxt = S_LHI;
      end
      S_LHI: begin
        hi_nxt    = rdata_r;
        rd_en     = 1'b1;
        rd_off    = FILL_W'(3);
        state_nxt = S_LLO;
      end
      S_LLO: begin
        if (blen_w > cfg.max_len) begin
          head_nxt  = ptr_wrap((FILL_W+1)'(head_r) + (FILL_W+1)'(1));
          fill_nxt  = fill_r - FILL_W'(1);
          state_nxt = S_CHK;
        end else if ((LEN_W+1)'(fill_r) <
                     ((LEN_W+1)'(blen_w) + (LEN_W+1)'(HDR_BYTES))) begin
          state_nxt = S_END;
        end else if (can_emit) begin
          emit                    = 1'b1;
          emit_item.is_header     = 1'b1;
          emit_item.frame_kind    = kind_r;
          emit_item.frame_tag     = tag_r;
          emit_item.body_length   = blen_w[BODY_LEN_W-1:0];
          emit_item.last_of_frame = (blen_w == '0);
          blen_nxt                = blen_w;
          cnt_nxt                 = '0;
          if (blen_w == '0) begin
            head_nxt  = ptr_wrap((FILL_W+1)'(head_r) + (FILL_W+1)'(HDR_BYTES));
            fill_nxt  = fill_r - FILL_W'(HDR_BYTES);
            state_nxt = S_CHK;
          end else begin
            rd_en     = 1'b1;
            rd_off    = FILL_W'(HDR_BYTES);
            state_nxt = S_BODY;
          end
        end
      end
      S_BODY: begin
        // Hold the read data while the result side is backed up.
        if (can_emit) begin
          emit                    = 1'b1;
          emit_item.is_header     = 1'b0;
          emit_item.frame_kind    = kind_r;
          emit_item.frame_tag     = tag_r;
          emit_item.body_length   = blen_r[BODY_LEN_W-1:0];
          emit_item.body_byte     = rdata_r;
          emit_item.last_of_frame = body_last;
          if (body_last) begin
            head_nxt  = ptr_wrap((FILL_W+1)'(head_r) + (FILL_W+1)'(tot_w));
            fill_nxt  = fill_r - tot_w;
            state_nxt = S_CHK;
          end else begin
            cnt_nxt   = cnt_r + FILL_W'(1);
            rd_en     = 1'b1;
            rd_off    = FILL_W'(HDR_BYTES) + cnt_r + FILL_W'(1);
          end
        end
      end
      S_END: begin
        if (!held_v_r) begin
          state_nxt = S_IDLE;
        end else if (!out_v_r || out_take) begin
          flush     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // One result is held back until it is known whether another follows.
  always_comb begin
    out_v_nxt  = out_v_r & !out_take;
    out_nxt    = out_r;
    held_v_nxt = held_v_r;
    held_nxt   = held_r;
    if (emit) begin
      if (held_v_r) begin
        out_nxt   = held_r;
        out_v_nxt = 1'b1;
      end
      held_nxt   = emit_item;
      held_v_nxt = 1'b1;
    end else if (flush) begin
      out_nxt             = held_r;
      out_nxt.last_of_run = 1'b1;
      out_v_nxt           = 1'b1;
      held_v_nxt          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wr_addr] <= q_ch.rx_byte;
    end
    if (rd_en) begin
      rdata_r <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    tag_r  <= tag_nxt;
    hi_r   <= hi_nxt;
    blen_r <= blen_nxt;
    cnt_r  <= cnt_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      fill_r   <= '0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      held_v_r <= held_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.is_header     = out_r.is_header;
  assign out_ch.frame_kind    = out_r.frame_kind;
  assign out_ch.frame_tag     = out_r.frame_tag;
  assign out_ch.body_length   = out_r.body_length;
  assign out_ch.body_byte     = out_r.body_byte;
  assign out_ch.last_of_frame = out_r.last_of_frame;
  assign out_ch.last_of_run   = out_r.last_of_run;

  `RFD_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(WIN_DEPTH), "window fill above depth")
  `RFD_ASSERT_ALWAYS(a_head_bound, FILL_W'(head_r) < FILL_W'(WIN_DEPTH), "head out of window")
  `RFD_ASSERT_IMPLY(a_idle_no_held, state_r == S_IDLE, !held_v_r, "result held while idle")
  `RFD_ASSERT_IMPLY(a_body_count, state_r == S_BODY, LEN_W'(cnt_r) < blen_r, "body count overrun")

endmodule

### sv/resync_frame_deframer.sv
// ----------------------------------------------------------------------------
// Resync frame deframer
// Recovers length-prefixed frames (kind, tag, 16-bit big-endian length, body)
// from a byte stream and resynchronizes after false headers.
//
// in_ch carries one received byte per beat; out_ch carries one result per
// beat: a header result, then one result per body byte, last_of_frame on the
// final result of a frame and last_of_run on the final result of one byte.
// The user must write the known kind mask (index 0) and the maximum body
// length (index 1) on the cfg port only while idle; it is not enforced.
// A byte enters a four-deep queue. The scanner takes it into the window and
// takes no new byte until it is done with it. For each header candidate it
// drops one byte on an unknown kind or an over-limit length, else emits a
// header result and one result per body byte; it stops when the window holds
// less than a header or than the whole frame. All reads go through the one
// read port of the window memory.
// Reset empties the window and queue and restores the register defaults. A
// stalled receiver stops the scanner once one result is registered and one
// is held; the queue keeps taking bytes until full.
// ----------------------------------------------------------------------------
module resync_frame_deframer import rfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rfd_byte_if.sink              in_ch,
  rfd_result_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rfd_cfg_t cfg_r, cfg_nxt;

  rfd_byte_if q_ch ();

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND_MASK: cfg_nxt.kind_mask = cfg_wdata[KIND_MASK_W-1:0];
        CFG_MAX_LEN:   cfg_nxt.max_len   = cfg_wdata[LEN_W-1:0];
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind_mask <= KIND_MASK_RST;
      cfg_r.max_len   <= MAX_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rfd_byte_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_ch  (q_ch)
  );

  rfd_scanner u_scanner (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_ch   (q_ch),
    .out_ch (out_ch)
  );

endmodule
